// ----- rtl/vppc_pkg.sv -----
// Package with types, codes and constants shared by the voice prompt controller.
`timescale 1ns / 1ps

package vppc_pkg;

    // Field widths
    localparam int TYPE_W    = 3;
    localparam int BYTE_W    = 8;
    localparam int DUR_W     = 12;
    localparam int TPS_W     = 10;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DAT_W = 10;
    localparam int IN_DATA_W  = 16;
    localparam int OUT_DATA_W = 16;

    // Default countdown width in bits
    localparam int COUNTDOWN_WIDTH = 22;

    // Prompt type codes
    localparam logic [TYPE_W-1:0] TYPE_MUTE  = 3'd0;
    localparam logic [TYPE_W-1:0] TYPE_ALARM = 3'd1;
    localparam logic [TYPE_W-1:0] TYPE_DUTY  = 3'd2;
    localparam logic [TYPE_W-1:0] TYPE_HOST  = 3'd3;
    localparam logic [TYPE_W-1:0] TYPE_LOCAL = 3'd4;
    localparam logic [TYPE_W-1:0] TYPE_SELF  = 3'd5;

    // Request kinds carried in the input user bit
    localparam logic CMD_REQUEST = 1'b0;
    localparam logic CMD_TICK    = 1'b1;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_CODE_MUTE   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_CODE_ALARM  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_CODE_DUTY   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_CODE_HOST   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_CODE_LOCAL  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_CODE_SELF   = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_PLAY_CMD    = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_TICKS_PER_S = 3'd7;

    // Configuration register reset values
    localparam logic [BYTE_W-1:0] RST_CODE_MUTE  = 8'd85;
    localparam logic [BYTE_W-1:0] RST_CODE_ALARM = 8'd1;
    localparam logic [BYTE_W-1:0] RST_CODE_DUTY  = 8'd2;
    localparam logic [BYTE_W-1:0] RST_CODE_HOST  = 8'd3;
    localparam logic [BYTE_W-1:0] RST_CODE_LOCAL = 8'd4;
    localparam logic [BYTE_W-1:0] RST_CODE_SELF  = 8'd5;
    localparam logic [BYTE_W-1:0] RST_PLAY_CMD   = 8'd242;
    localparam logic [TPS_W-1:0]  RST_TICKS_PER_S = 10'd200;

    // Configuration register file
    typedef struct packed {
        logic [BYTE_W-1:0] code_mute;
        logic [BYTE_W-1:0] code_alarm;
        logic [BYTE_W-1:0] code_duty;
        logic [BYTE_W-1:0] code_host_fault;
        logic [BYTE_W-1:0] code_local_fault;
        logic [BYTE_W-1:0] code_self_check;
        logic [BYTE_W-1:0] play_command;
        logic [TPS_W-1:0]  ticks_per_second;
    } cfg_t;

    // Decision for one request: how many bytes go out and what they are
    typedef struct packed {
        logic [1:0]        count;
        logic [BYTE_W-1:0] byte0;
        logic [BYTE_W-1:0] byte1;
        logic              type_we;
        logic [TYPE_W-1:0] new_type;
        logic              cd_we;
    } decision_t;

endpackage

// ----- rtl/vppc_decide.sv -----
// Priority decision, countdown update and output bytes for one request.
`timescale 1ns / 1ps

module vppc_decide
    import vppc_pkg::*;
#(
    parameter int CW = COUNTDOWN_WIDTH
)
(
    input  logic              cmd,
    input  logic [TYPE_W-1:0] voice_type,
    input  logic              halt,
    input  logic [DUR_W-1:0]  duration_s,
    input  logic [TYPE_W-1:0] playing_type,
    input  logic [CW-1:0]     countdown,
    input  cfg_t              cfg,
    output decision_t         dec,
    output logic [CW-1:0]     countdown_next
);

    localparam int PROD_W = DUR_W + TPS_W;

    logic [PROD_W-1:0] prod;
    logic [CW-1:0]     load;
    logic              mute_req;
    logic              play;
    logic [BYTE_W-1:0] type_code;

    // Duration in ticks, saturated to the countdown width
    assign prod = PROD_W'(duration_s) * PROD_W'(cfg.ticks_per_second);

    generate
        if (CW >= PROD_W) begin : g_wide
            assign load = CW'(prod);
        end
        else begin : g_sat
            assign load = (|prod[PROD_W-1:CW]) ? {CW{1'b1}} : prod[CW-1:0];
        end
    endgenerate

    // Mute request: mute while not on duty, or halt of the prompt now playing
    assign mute_req = ((playing_type != TYPE_DUTY) && (voice_type == TYPE_MUTE)) ||
                      (halt && (voice_type == playing_type));

    // Priority rule for starting a new prompt
    always_comb
    begin
        case (voice_type)
            TYPE_ALARM: play = 1'b1;
            TYPE_DUTY:  play = (playing_type != TYPE_ALARM);
            TYPE_HOST:  play = (playing_type != TYPE_ALARM) && (playing_type != TYPE_DUTY);
            TYPE_LOCAL: play = (playing_type == TYPE_MUTE) || (playing_type == TYPE_SELF);
            TYPE_SELF:  play = (playing_type == TYPE_MUTE);
            default:    play = 1'b0;
        endcase
    end

    // Address byte of the requested prompt
    always_comb
    begin
        case (voice_type)
            TYPE_ALARM: type_code = cfg.code_alarm;
            TYPE_DUTY:  type_code = cfg.code_duty;
            TYPE_HOST:  type_code = cfg.code_host_fault;
            TYPE_LOCAL: type_code = cfg.code_local_fault;
            TYPE_SELF:  type_code = cfg.code_self_check;
            default:    type_code = cfg.code_mute;
        endcase
    end

    // Outcome of a tick or a prompt request
    always_comb
    begin
        dec.count      = 2'd0;
        dec.byte0      = cfg.code_mute;
        dec.byte1      = cfg.play_command;
        dec.type_we    = 1'b0;
        dec.new_type   = TYPE_MUTE;
        dec.cd_we      = 1'b0;
        countdown_next = countdown - CW'(1);
        if (cmd == CMD_TICK) begin
            if (countdown != '0) begin
                dec.cd_we = 1'b1;
                if (countdown == CW'(1)) begin
                    dec.count   = 2'd1;
                    dec.type_we = 1'b1;
                end
            end
        end
        else if (mute_req) begin
            dec.count   = 2'd1;
            dec.type_we = 1'b1;
        end
        else begin
            dec.cd_we      = 1'b1;
            countdown_next = load;
            if (play) begin
                dec.count    = 2'd2;
                dec.byte0    = type_code;
                dec.type_we  = 1'b1;
                dec.new_type = voice_type;
            end
        end
    end

endmodule

// ----- rtl/voice_prompt_priority_controller_core.sv -----
// Top level of the voice prompt priority controller.
`timescale 1ns / 1ps
// Usage:
// Requests enter on the s_axis channel: tuser is the kind (0 prompt request,
// 1 timer tick), tdata carries the prompt type, halt flag and duration.
// Each request yields zero, one or two bytes for the voice chip on the
// m_axis channel; tlast marks the final byte of a request. A started prompt
// sends its address byte and then the play command; a mute sends one byte.
// Configuration registers are written over the cfg channel, always ready,
// and are meant to change only while no request is in flight.
// A request is registered in the input register, decided combinationally
// from it, and its bytes are registered in the output register before
// they reach m_axis. The output sends one byte per cycle while the
// receiver is ready; mutes, ticks and ignored requests are taken at one
// request per cycle, while a request that starts a prompt holds the
// two-byte output register until its second byte is sent. The input
// register takes the next request while the output still holds bytes, so
// a stalled receiver stops the block only once both registers are full.
// Reset mutes, stops the countdown and loads the default register values.

module voice_prompt_priority_controller_core
    import vppc_pkg::*;
#(
    parameter int CW = COUNTDOWN_WIDTH
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    // Request channel
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    // tdata: voice_type[2:0], halt[3], duration_s[15:4]
    input  logic [IN_DATA_W-1:0]   s_axis_tdata,
    // tuser: cmd
    input  logic                   s_axis_tuser,
    // Result channel
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    // tdata: send_valid[0], send_byte[8:1], current_type[11:9], zero[15:12]
    output logic [OUT_DATA_W-1:0]  m_axis_tdata,
    output logic                   m_axis_tlast,
    // Configuration write channel
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [CFG_IDX_W-1:0]   cfg_index,
    input  logic [CFG_DAT_W-1:0]   cfg_data
);

    cfg_t              cfg_reg;
    logic              in_valid_reg;
    logic              cmd_reg;
    logic [TYPE_W-1:0] vtype_reg;
    logic              halt_reg;
    logic [DUR_W-1:0]  dur_reg;
    logic [TYPE_W-1:0] playing_type_reg;
    logic [CW-1:0]     countdown_reg;
    logic [CW-1:0]     countdown_next;
    logic [1:0]        pend_reg;
    logic [BYTE_W-1:0] byte0_reg;
    logic [BYTE_W-1:0] byte1_reg;
    logic [TYPE_W-1:0] out_type_reg;
    decision_t         dec;
    logic              proc;
    logic              out_fire;
    logic              in_fire;

    // Handshakes
    assign cfg_ready     = 1'b1;
    assign out_fire      = m_axis_tvalid && m_axis_tready;
    assign proc          = in_valid_reg && ((pend_reg == 2'd0) ||
                                            ((pend_reg == 2'd1) && m_axis_tready));
    assign s_axis_tready = !in_valid_reg || proc;
    assign in_fire       = s_axis_tvalid && s_axis_tready;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            cfg_reg.code_mute        <= RST_CODE_MUTE;
            cfg_reg.code_alarm       <= RST_CODE_ALARM;
            cfg_reg.code_duty        <= RST_CODE_DUTY;
            cfg_reg.code_host_fault  <= RST_CODE_HOST;
            cfg_reg.code_local_fault <= RST_CODE_LOCAL;
            cfg_reg.code_self_check  <= RST_CODE_SELF;
            cfg_reg.play_command     <= RST_PLAY_CMD;
            cfg_reg.ticks_per_second <= RST_TICKS_PER_S;
        end
        else if (cfg_valid) begin
            unique case (cfg_index)
                REG_CODE_MUTE:   cfg_reg.code_mute        <= cfg_data[BYTE_W-1:0];
                REG_CODE_ALARM:  cfg_reg.code_alarm       <= cfg_data[BYTE_W-1:0];
                REG_CODE_DUTY:   cfg_reg.code_duty        <= cfg_data[BYTE_W-1:0];
                REG_CODE_HOST:   cfg_reg.code_host_fault  <= cfg_data[BYTE_W-1:0];
                REG_CODE_LOCAL:  cfg_reg.code_local_fault <= cfg_data[BYTE_W-1:0];
                REG_CODE_SELF:   cfg_reg.code_self_check  <= cfg_data[BYTE_W-1:0];
                REG_PLAY_CMD:    cfg_reg.play_command     <= cfg_data[BYTE_W-1:0];
                REG_TICKS_PER_S: cfg_reg.ticks_per_second <= cfg_data[TPS_W-1:0];
            endcase
        end
    end

    // Input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            in_valid_reg <= 1'b0;
        end
        else if (s_axis_tready) begin
            in_valid_reg <= s_axis_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire) begin
            cmd_reg   <= s_axis_tuser;
            vtype_reg <= s_axis_tdata[TYPE_W-1:0];
            halt_reg  <= s_axis_tdata[TYPE_W];
            dur_reg   <= s_axis_tdata[TYPE_W+1 +: DUR_W];
        end
    end

    // Decision logic
    vppc_decide #(
        .CW (CW)
    ) u_decide (
        .cmd            (cmd_reg),
        .voice_type     (vtype_reg),
        .halt           (halt_reg),
        .duration_s     (dur_reg),
        .playing_type   (playing_type_reg),
        .countdown      (countdown_reg),
        .cfg            (cfg_reg),
        .dec            (dec),
        .countdown_next (countdown_next)
    );

    // Prompt state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            playing_type_reg <= TYPE_MUTE;
            countdown_reg    <= '0;
        end
        else if (proc) begin
            if (dec.type_we) begin
                playing_type_reg <= dec.new_type;
            end
            if (dec.cd_we) begin
                countdown_reg <= countdown_next;
            end
        end
    end

    // Output register: up to two bytes per request, sent in order
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            pend_reg <= 2'd0;
        end
        else if (proc) begin
            pend_reg <= dec.count;
        end
        else if (out_fire) begin
            pend_reg <= pend_reg - 2'd1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (proc) begin
            byte0_reg    <= dec.byte0;
            byte1_reg    <= dec.byte1;
            out_type_reg <= dec.type_we ? dec.new_type : playing_type_reg;
        end
        else if (out_fire) begin
            byte0_reg <= byte1_reg;
        end
    end

    assign m_axis_tvalid = (pend_reg != 2'd0);
    assign m_axis_tlast  = (pend_reg == 2'd1);
    assign m_axis_tdata  = {{(OUT_DATA_W - 1 - BYTE_W - TYPE_W){1'b0}},
                            out_type_reg, byte0_reg, 1'b1};

endmodule
